// ===== src/cfr_pkg.sv =====
// Shared types and constants for the chunk framer.
// No dependencies; cfr_front, cfr_back and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    // Wide enough for the largest supported chunk size.
    localparam int LEN_W = 6;

    localparam logic [7:0] MARK_MORE = 8'h4E;   // 'N'
    localparam logic [7:0] MARK_LAST = 8'h4C;   // 'L'

    // Header layout: marker, then four length bytes, then payload.
    localparam int HDR_MARK      = 0;
    localparam int HDR_LEN0      = 1;
    localparam int PAYLOAD_START = 5;

    // One closed chunk handed from the front to the back.
    typedef struct packed {
        logic             last;
        logic             bank;
        logic [LEN_W-1:0] len;
    } cfr_desc_t;

    // One frame byte on the result side.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } cfr_item_t;

endpackage

`default_nettype wire

// ===== src/cfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/cfr_fifo.sv =====
// Small register FIFO used for the chunk descriptor queue and the result queue.
// No dependencies; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module cfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rdata,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/cfr_front.sv =====
// Front end: accepts stream bytes, writes them into the current chunk bank
// and closes a chunk into a descriptor. Depends on cfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfr_front #(
    parameter int CHUNK_BYTES = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   final_byte,
    output logic                        ram_we,
    output logic [((CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1):0] ram_waddr,
    output logic [7:0]                  ram_wdata,
    output logic                        desc_push,
    output cfr_pkg::cfr_desc_t          desc,
    input  wire logic                   desc_full
);

    import cfr_pkg::*;

    localparam int IW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CW = $clog2(CHUNK_BYTES + 1);

    logic [CW-1:0] fill_reg, fill_next;
    logic          bank_reg, bank_next;
    logic [CW-1:0] count_inc;
    logic          accept;
    logic          close;

    // A bank may be filled only while fewer than two chunks wait or drain.
    assign full      = desc_full;
    assign accept    = push && !desc_full;
    assign count_inc = fill_reg + CW'(1);
    assign close     = accept && ((count_inc == CW'(CHUNK_BYTES)) || final_byte);

    assign ram_we    = accept;
    assign ram_waddr = {bank_reg, fill_reg[IW-1:0]};
    assign ram_wdata = data_byte;

    assign desc_push = close;
    assign desc.last = final_byte;
    assign desc.bank = bank_reg;
    assign desc.len  = LEN_W'(count_inc);

    always_comb
    begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        if (close)
        begin
            fill_next = '0;
            bank_next = !bank_reg;
        end
        else if (accept)
        begin
            fill_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            bank_reg <= bank_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/cfr_back.sv =====
// Back end: walks a closed chunk as marker, length and payload bytes,
// reading payload from the chunk RAM into a result queue. Depends on cfr_pkg
// and cfr_fifo.
`timescale 1ns / 1ps
`default_nettype none

module cfr_back #(
    parameter int CHUNK_BYTES = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   desc_valid,
    input  wire cfr_pkg::cfr_desc_t     desc,
    output logic                        desc_pop,
    output logic                        ram_re,
    output logic [((CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1):0] ram_raddr,
    input  wire logic [7:0]             ram_rdata,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  out_byte,
    output logic                        frame_end,
    output logic                        item_push,
    output logic                        item_full
);

    import cfr_pkg::*;

    localparam int IW     = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int PW     = $clog2(CHUNK_BYTES + PAYLOAD_START);
    localparam int ODEPTH = 2;
    localparam int OCW    = $clog2(ODEPTH + 1);

    localparam logic [PW-1:0] P_MARK  = PW'(HDR_MARK);
    localparam logic [PW-1:0] P_LEN0  = PW'(HDR_LEN0);
    localparam logic [PW-1:0] P_START = PW'(PAYLOAD_START);

    logic [PW-1:0]  pos_reg, pos_next;
    logic           s1_valid_reg;
    logic           s1_ram_reg;
    logic [7:0]     s1_byte_reg;
    logic           s1_end_reg;
    logic [OCW-1:0] out_count;
    logic [OCW:0]   pending;
    logic           issue;
    logic           is_payload;
    logic           is_end;
    logic [PW-1:0]  end_pos;
    logic [PW-1:0]  pay_idx;
    logic [7:0]     hdr_byte;
    cfr_item_t      item_in, item_out;
    logic           unused_empty_q;

    // One byte is issued only if the result queue can take it after the RAM read.
    assign pending    = {1'b0, out_count} + (OCW + 1)'(s1_valid_reg);
    assign issue      = desc_valid && (pending < (OCW + 1)'(ODEPTH));
    assign end_pos    = PW'(desc.len) + P_START - PW'(1);
    assign is_end     = (pos_reg == end_pos);
    assign is_payload = (pos_reg >= P_START);
    assign pay_idx    = pos_reg - P_START;

    assign desc_pop   = issue && is_end;
    assign ram_re     = issue && is_payload;
    assign ram_raddr  = {desc.bank, pay_idx[IW-1:0]};

    always_comb
    begin
        case (pos_reg)
            P_MARK:  hdr_byte = desc.last ? MARK_LAST : MARK_MORE;
            P_LEN0:  hdr_byte = 8'(desc.len);
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (issue)
        begin
            pos_next = is_end ? '0 : pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_ram_reg  <= is_payload;
            s1_byte_reg <= hdr_byte;
            s1_end_reg  <= is_end;
        end
    end

    assign item_in.out_byte  = s1_ram_reg ? ram_rdata : s1_byte_reg;
    assign item_in.frame_end = s1_end_reg;
    assign item_push         = s1_valid_reg;

    cfr_fifo #(
        .WIDTH ($bits(cfr_item_t)),
        .DEPTH (ODEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (s1_valid_reg),
        .wdata (item_in),
        .rd_en (pop),
        .rdata (item_out),
        .full  (item_full),
        .empty (unused_empty_q),
        .count (out_count)
    );

    assign empty     = unused_empty_q;
    assign out_byte  = item_out.out_byte;
    assign frame_end = item_out.frame_end;

endmodule

`default_nettype wire

// ===== src/chunk_framer_with_last_marker.sv =====
// Chunk framer with last-byte marker: top level.
// Uses cfr_pkg, cfr_ram, cfr_fifo, cfr_front and cfr_back.
//
// Input channel: a stream byte on data_byte with final_byte set on the last
// byte of the stream; an item is taken when push is high and full is low.
// Result channel: frame bytes on out_byte with frame_end set on the last
// payload byte of each frame; the oldest byte is shown while empty is low
// and is removed when pop is high.
// A frame is the marker ('N', or 'L' for the final frame), the payload
// length in four bytes least significant first, then the payload.
// Input bytes go into one of two chunk banks in the chunk RAM, one byte per
// cycle while full is low. A closed chunk becomes a descriptor in a two-entry
// queue. The back end waits on its two-entry result queue: it issues a new
// frame byte only while the queue and its RAM read stage together hold fewer
// than two bytes, so it can stall even with pop held high. The first frame
// byte passes through the descriptor queue, the back end read stage and the
// result queue before it is shown.
// full rises while two closed chunks are still waiting or draining.
// When the receiver stalls, the result queue fills, the back end halts and,
// once both banks are held, full stops the input. Reset empties every
// queue and restarts the fill count; the RAM contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module chunk_framer_with_last_marker #(
    parameter int CHUNK_BYTES = 20
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic      [7:0] out_byte,
    output logic            frame_end
);

    import cfr_pkg::*;

    localparam int IW        = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int RAM_DEPTH = 2 * (1 << IW);
    localparam int DQ_DEPTH  = 2;

    logic                      ram_we, ram_re;
    logic [IW:0]               ram_waddr, ram_raddr;
    logic [7:0]                ram_wdata, ram_rdata;
    logic                      dq_push, dq_pop, dq_full, dq_empty;
    logic [$clog2(DQ_DEPTH+1)-1:0] dq_count;
    cfr_desc_t                 desc_in, desc_out;
    logic                      item_push, item_full;

    cfr_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .desc_push  (dq_push),
        .desc       (desc_in),
        .desc_full  (dq_full)
    );

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfr_fifo #(
        .WIDTH ($bits(cfr_desc_t)),
        .DEPTH (DQ_DEPTH)
    ) u_desc_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (dq_push),
        .wdata (desc_in),
        .rd_en (dq_pop),
        .rdata (desc_out),
        .full  (dq_full),
        .empty (dq_empty),
        .count (dq_count)
    );

    cfr_back #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (!dq_empty),
        .desc       (desc_out),
        .desc_pop   (dq_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .frame_end  (frame_end),
        .item_push  (item_push),
        .item_full  (item_full)
    );

    // The back end must never issue a byte the result queue cannot hold.
    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_push && item_full))
        else $error("result queue written while full");

    // A closed chunk must always find room in the descriptor queue.
    a_desc_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(dq_push && dq_full))
        else $error("descriptor queue written while full");

    // A final byte always leaves a chunk waiting for the back end.
    a_final_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && final_byte) |=> (dq_count != '0))
        else $error("final byte did not close a chunk");

    // The chunk RAM is never read and written at the same address.
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr[IW] != ram_raddr[IW]))
        else $error("front and back touch the same chunk bank");

endmodule

`default_nettype wire
